### sv/dom_pkg.sv
// dom_pkg: shared widths, request codes and payload types of the detection overlap matcher.
// No dependencies; imported by every module of the block.
package dom_pkg;

   localparam int COORD_W = 12;
   localparam int SIZE_W  = 11;
   localparam int OFS_W   = 11;
   localparam int TOTAL_W = 32;
   // box edges (left plus width) need one more bit than a coordinate, plus sign headroom
   localparam int EDGE_W  = COORD_W + 2;
   localparam int SPAN_W  = COORD_W + 1;
   localparam int AREA_W  = 2 * SPAN_W;

   localparam logic [OFS_W-1:0]   CROP_X_RESET = OFS_W'(1280 / 4);
   localparam logic [OFS_W-1:0]   CROP_Y_RESET = OFS_W'(720 / 4);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_DETECT = 2'd1;
   localparam logic [1:0] REQ_EOF    = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_DETECT,
      OP_EOF,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SIZE_W-1:0]         w;
      logic [SIZE_W-1:0]         h;
   } box_type;

   typedef struct packed {
      op_type  op;
      box_type box;
   } cmd_type;

   typedef struct packed {
      logic [1:0]                req_type;
      logic signed [COORD_W-1:0] box_x;
      logic signed [COORD_W-1:0] box_y;
      logic [SIZE_W-1:0]         box_w;
      logic [SIZE_W-1:0]         box_h;
   } req_item_type;

   typedef struct packed {
      logic               matched;
      logic               table_overflow;
      logic [TOTAL_W-1:0] true_pos_total;
      logic [TOTAL_W-1:0] false_pos_total;
      logic [TOTAL_W-1:0] false_neg_total;
      logic [TOTAL_W-1:0] truth_total;
      logic [TOTAL_W-1:0] detect_total;
   } rsp_item_type;

endpackage

### sv/dom_front.sv
// dom_front: request decode, crop adjustment of ground-truth boxes and the command queue.
// Depends on dom_pkg.
module dom_front import dom_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [OFS_W-1:0]   crop_x,
   input  logic [OFS_W-1:0]   crop_y,
   input  logic               push,
   output logic               full,
   input  req_item_type       req_item,
   output logic               cmd_valid,
   input  logic               cmd_pop,
   output cmd_type            cmd_head
);

   localparam int QDEPTH = 2;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   cmd_type           q_ff [QDEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;
   cmd_type           cmd_new;

   // subtract the offset and clamp to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [COORD_W-1:0] v,
      input logic [OFS_W-1:0]          ofs
   );
      logic signed [COORD_W:0] d;
      d = $signed({v[COORD_W-1], v}) - $signed({{(COORD_W + 1 - OFS_W){1'b0}}, ofs});
      if (d[COORD_W] != d[COORD_W-1]) begin
         return d[COORD_W] ? {1'b1, {(COORD_W - 1){1'b0}}} : {1'b0, {(COORD_W - 1){1'b1}}};
      end
      return d[COORD_W-1:0];
   endfunction

   always_comb begin
      cmd_new.box.x = req_item.box_x;
      cmd_new.box.y = req_item.box_y;
      cmd_new.box.w = req_item.box_w;
      cmd_new.box.h = req_item.box_h;
      unique case (req_item.req_type)
         REQ_LOAD: begin
            cmd_new.op    = OP_LOAD;
            cmd_new.box.x = sat_coord(req_item.box_x, crop_x);
            cmd_new.box.y = sat_coord(req_item.box_y, crop_y);
         end
         REQ_DETECT: cmd_new.op = OP_DETECT;
         REQ_EOF:    cmd_new.op = OP_EOF;
         default:    cmd_new.op = OP_NONE;
      endcase
   end

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_head  = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

### sv/dom_back.sv
// dom_back: truth table memory, overlap scan pipeline, saturating totals and result register.
// Depends on dom_pkg; fed by dom_front.
module dom_back import dom_pkg::*; #(
   parameter int MAX_TRUTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   output logic         cmd_pop,
   input  cmd_type      cmd_head,
   input  logic         pop,
   output logic         empty,
   output rsp_item_type rsp_item
);

   localparam int IDX_W  = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
   localparam int FILL_W = $clog2(MAX_TRUTH + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   box_type            mem [MAX_TRUTH];
   box_type            rd_ff;
   box_type            det_ff, det_in;
   logic [MAX_TRUTH-1:0] valid_ff, valid_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  live_ff, live_in;
   logic [FILL_W-1:0]  issue_ff, issue_in;
   logic [TOTAL_W-1:0] tp_ff, tp_in, fp_ff, fp_in, fn_ff, fn_in;
   logic [TOTAL_W-1:0] gt_ff, gt_in, dt_ff, dt_in;
   logic [TOTAL_W:0]   fn_sum;
   logic               matched_ff, matched_in, overflow_ff, overflow_in;
   rsp_item_type       out_ff, out_in;
   logic               out_vld_ff, out_vld_in;
   logic               out_wr, wr_en;

   // scan pipeline
   logic               p1_vld_ff, p1_vld_in, p1_live_ff;
   logic [IDX_W-1:0]   p1_idx_ff;
   logic               p2_vld_ff, p2_ok_ff, p2_ok_in;
   logic [IDX_W-1:0]   p2_idx_ff;
   logic [SPAN_W-1:0]  p2_cap_dx_ff, p2_cap_dy_ff, p2_cup_dx_ff, p2_cup_dy_ff;
   logic [SPAN_W-1:0]  cap_dx_in, cap_dy_in, cup_dx_in, cup_dy_in;
   logic               p3_vld_ff, p3_ok_ff;
   logic [IDX_W-1:0]   p3_idx_ff;
   logic [AREA_W-1:0]  p3_cap_ff, p3_cup_ff;
   logic               hit, issue_go;

   logic signed [EDGE_W-1:0] gx0, gx1, gy0, gy1, dx0, dx1, dy0, dy1;
   logic signed [EDGE_W-1:0] ix0, ix1, iy0, iy1, ux0, ux1, uy0, uy1;

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      return (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
   endfunction

   // overlap geometry on the entry just read and the held detection
   always_comb begin
      gx0 = EDGE_W'(rd_ff.x);
      gy0 = EDGE_W'(rd_ff.y);
      dx0 = EDGE_W'(det_ff.x);
      dy0 = EDGE_W'(det_ff.y);
      gx1 = gx0 + $signed(EDGE_W'(rd_ff.w));
      gy1 = gy0 + $signed(EDGE_W'(rd_ff.h));
      dx1 = dx0 + $signed(EDGE_W'(det_ff.w));
      dy1 = dy0 + $signed(EDGE_W'(det_ff.h));
      ix0 = (gx0 > dx0) ? gx0 : dx0;
      iy0 = (gy0 > dy0) ? gy0 : dy0;
      ix1 = (gx1 < dx1) ? gx1 : dx1;
      iy1 = (gy1 < dy1) ? gy1 : dy1;
      ux0 = (gx0 < dx0) ? gx0 : dx0;
      uy0 = (gy0 < dy0) ? gy0 : dy0;
      ux1 = (gx1 > dx1) ? gx1 : dx1;
      uy1 = (gy1 > dy1) ? gy1 : dy1;
      cap_dx_in = (ix1 > ix0) ? SPAN_W'(ix1 - ix0) : '0;
      cap_dy_in = (iy1 > iy0) ? SPAN_W'(iy1 - iy0) : '0;
      cup_dx_in = SPAN_W'(ux1 - ux0);
      cup_dy_in = SPAN_W'(uy1 - uy0);
      // a box with no width or height never matches
      p2_ok_in  = p1_live_ff && (rd_ff.w != '0) && (rd_ff.h != '0)
                  && (det_ff.w != '0) && (det_ff.h != '0);
   end

   assign hit      = p3_vld_ff && p3_ok_ff && ({p3_cap_ff, 1'b0} >= {1'b0, p3_cup_ff});
   assign issue_go = (state_ff == S_SCAN) && (issue_ff < fill_ff) && !hit;
   assign wr_en    = (state_ff == S_IDLE) && cmd_valid && (cmd_head.op == OP_LOAD)
                     && (fill_ff != FILL_W'(MAX_TRUTH));
   assign fn_sum   = {1'b0, fn_ff} + (TOTAL_W + 1)'(live_ff);

   always_comb begin
      state_in    = state_ff;
      det_in      = det_ff;
      valid_in    = valid_ff;
      fill_in     = fill_ff;
      live_in     = live_ff;
      issue_in    = issue_ff;
      tp_in       = tp_ff;
      fp_in       = fp_ff;
      fn_in       = fn_ff;
      gt_in       = gt_ff;
      dt_in       = dt_ff;
      matched_in  = matched_ff;
      overflow_in = overflow_ff;
      cmd_pop     = 1'b0;
      out_wr      = 1'b0;
      p1_vld_in   = issue_go;
      if (issue_go) begin
         issue_in = issue_ff + FILL_W'(1);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               matched_in  = 1'b0;
               overflow_in = 1'b0;
               state_in    = S_EMIT;
               unique case (cmd_head.op)
                  OP_LOAD: begin
                     if (wr_en) begin
                        valid_in[fill_ff[IDX_W-1:0]] = 1'b1;
                        fill_in = fill_ff + FILL_W'(1);
                        live_in = live_ff + FILL_W'(1);
                        gt_in   = sat_inc(gt_ff);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  OP_DETECT: begin
                     dt_in    = sat_inc(dt_ff);
                     det_in   = cmd_head.box;
                     issue_in = '0;
                     state_in = S_SCAN;
                  end
                  OP_EOF: begin
                     fn_in    = fn_sum[TOTAL_W] ? TOTAL_MAX : fn_sum[TOTAL_W-1:0];
                     live_in  = '0;
                     fill_in  = '0;
                     valid_in = '0;
                  end
                  OP_NONE: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (hit) begin
               valid_in[p3_idx_ff] = 1'b0;
               live_in    = live_ff - FILL_W'(1);
               tp_in      = sat_inc(tp_ff);
               matched_in = 1'b1;
               state_in   = S_EMIT;
            end else if ((issue_ff == fill_ff) && !p1_vld_ff && !p2_vld_ff && !p3_vld_ff) begin
               fp_in    = sat_inc(fp_ff);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!out_vld_ff || pop) begin
               out_wr   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_in.matched         = matched_ff;
      out_in.table_overflow  = overflow_ff;
      out_in.true_pos_total  = tp_ff;
      out_in.false_pos_total = fp_ff;
      out_in.false_neg_total = fn_ff;
      out_in.truth_total     = gt_ff;
      out_in.detect_total    = dt_ff;
      out_vld_in = out_wr ? 1'b1 : (pop ? 1'b0 : out_vld_ff);
   end

   assign empty    = !out_vld_ff;
   assign rsp_item = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         valid_ff    <= '0;
         fill_ff     <= '0;
         live_ff     <= '0;
         issue_ff    <= '0;
         tp_ff       <= '0;
         fp_ff       <= '0;
         fn_ff       <= '0;
         gt_ff       <= '0;
         dt_ff       <= '0;
         matched_ff  <= 1'b0;
         overflow_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         p1_vld_ff   <= 1'b0;
         p2_vld_ff   <= 1'b0;
         p3_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         fill_ff     <= fill_in;
         live_ff     <= live_in;
         issue_ff    <= issue_in;
         tp_ff       <= tp_in;
         fp_ff       <= fp_in;
         fn_ff       <= fn_in;
         gt_ff       <= gt_in;
         dt_ff       <= dt_in;
         matched_ff  <= matched_in;
         overflow_ff <= overflow_in;
         out_vld_ff  <= out_vld_in;
         p1_vld_ff   <= p1_vld_in;
         p2_vld_ff   <= p1_vld_ff && !hit;
         p3_vld_ff   <= p2_vld_ff && !hit;
      end
   end

   // table memory: one write port at the fill position, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[IDX_W-1:0]] <= cmd_head.box;
      end
      rd_ff <= mem[issue_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      det_ff       <= det_in;
      out_ff       <= out_wr ? out_in : out_ff;
      p1_live_ff   <= valid_ff[issue_ff[IDX_W-1:0]];
      p1_idx_ff    <= issue_ff[IDX_W-1:0];
      p2_ok_ff     <= p2_ok_in;
      p2_idx_ff    <= p1_idx_ff;
      p2_cap_dx_ff <= cap_dx_in;
      p2_cap_dy_ff <= cap_dy_in;
      p2_cup_dx_ff <= cup_dx_in;
      p2_cup_dy_ff <= cup_dy_in;
      p3_ok_ff     <= p2_ok_ff;
      p3_idx_ff    <= p2_idx_ff;
      p3_cap_ff    <= AREA_W'(p2_cap_dx_ff) * AREA_W'(p2_cap_dy_ff);
      p3_cup_ff    <= AREA_W'(p2_cup_dx_ff) * AREA_W'(p2_cup_dy_ff);
   end

endmodule

### sv/detection_overlap_matcher.sv
// detection_overlap_matcher: top level with crop offset registers, front decode and back scan.
// Depends on dom_pkg, dom_front and dom_back.
// A load, frame end or unknown request passes the command queue and the emit state into the
// result register, and the back end takes the next request only once that result is written;
// a detection first scans the loaded entries, one per cycle, in the overlap pipeline until a match.
// Reset clears the queues, valid bits and totals and sets the offsets to 320 and 180.
module detection_overlap_matcher import dom_pkg::*; #(
   parameter int MAX_TRUTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   // request queue side
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   // result queue side
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item,
   // register port
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   // register select is the word address bit
   localparam logic REG_CROP_X = 1'b0;
   localparam logic REG_CROP_Y = 1'b1;

   logic [OFS_W-1:0] crop_x_ff, crop_x_in;
   logic [OFS_W-1:0] crop_y_ff, crop_y_in;
   logic             csr_wr;
   logic             cmd_valid, cmd_pop;
   cmd_type          cmd_head;

   // Offsets must be written by the user only while the block is idle (not enforced here),
   // so the front may apply them at request transfer without any tracking of in-flight items.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      crop_x_in = crop_x_ff;
      crop_y_in = crop_y_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_CROP_X: crop_x_in = pwdata[OFS_W-1:0];
            REG_CROP_Y: crop_y_in = pwdata[OFS_W-1:0];
            default:    crop_x_in = crop_x_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_CROP_X: prdata = 32'(crop_x_ff);
         REG_CROP_Y: prdata = 32'(crop_y_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crop_x_ff <= CROP_X_RESET;
         crop_y_ff <= CROP_Y_RESET;
      end else begin
         crop_x_ff <= crop_x_in;
         crop_y_ff <= crop_y_in;
      end
   end

   // Front: decode each request, adjust loaded boxes, hold them in a short queue.
   dom_front u_front (
      .clock     (clock),
      .reset     (reset),
      .crop_x    (crop_x_ff),
      .crop_y    (crop_y_ff),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_head  (cmd_head)
   );

   // Back: table, scan, totals and the result register that parts it from the consumer.
   dom_back #(
      .MAX_TRUTH (MAX_TRUTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_head  (cmd_head),
      .pop       (pop),
      .empty     (empty),
      .rsp_item  (rsp_item)
   );

endmodule

### sv/dom_checker.sv
// dom_checker: port-level checks of the detection overlap matcher, bound to the top level.
// Depends on dom_pkg and detection_overlap_matcher.
module dom_checker import dom_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         push,
   input logic         full,
   input logic         empty,
   input logic         pop,
   input rsp_item_type rsp_item
);

   // both queues come out of reset empty
   a_reset_clear: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not clear after reset");

   // a waiting result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_item))
      else $error("result changed while waiting");

   // true-positive and detection totals never fall from one result to the next
   a_tp_rising: assert property (@(posedge clock) disable iff (reset)
      !empty && pop |=> empty
         || (rsp_item.true_pos_total >= $past(rsp_item.true_pos_total)
             && rsp_item.detect_total >= $past(rsp_item.detect_total)))
      else $error("total decreased between results");

   // a match is counted at once and is never a dropped load
   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item.matched |-> rsp_item.true_pos_total != '0
         && rsp_item.detect_total != '0 && !rsp_item.table_overflow)
      else $error("matched result with inconsistent totals");

endmodule

bind detection_overlap_matcher dom_checker u_dom_checker (.*);
